@@ src/vzpg_pkg.sv @@
// ----------------------------------------------------------------------------
// vzpg_pkg: shared types for the view zoom/pan gesture block
// Controller states, command and status structs between control and datapath.
// ----------------------------------------------------------------------------
package vzpg_pkg;

    localparam int unsigned ONE_Q12 = 4096;

    localparam logic [1:0] REG_VP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_VP_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ASPECT    = 2'd2;
    localparam logic [1:0] REG_MAX_ZOOM  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ZOOM,
        ST_PANMUL,
        ST_PANDIV,
        ST_PANADD,
        ST_BASEDIV,
        ST_BASEW,
        ST_SIZE,
        ST_FIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic zoom;
        logic pan_mul;
        logic div_x_start;
        logic pan_add;
        logic base_start;
        logic base_w;
        logic size;
        logic fit;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic vp_zero;
        logic zoom_changed;
        logic has_aspect;
        logic div_busy;
    } status_t;

endpackage

@@ src/vzpg_div.sv @@
// ----------------------------------------------------------------------------
// vzpg_div: radix-2 restoring divider
// Unsigned quotient of a 48-bit numerator by a 24-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module vzpg_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] num,
    input  logic [23:0] den,
    output logic        busy,
    output logic [47:0] quo
);

    logic [47:0] q_reg, q_next;
    logic [24:0] r_reg, r_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [23:0] d_reg, d_next;
    logic        busy_reg, busy_next;
    logic [24:0] sh;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        sh = {r_reg[23:0], q_reg[47]};
        if (start) begin
            q_next = num;
            r_next = '0;
            d_next = den;
            cnt_next = 6'd48;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (sh >= {1'b0, d_reg}) begin
                r_next = sh - {1'b0, d_reg};
                q_next = {q_reg[46:0], 1'b1};
            end else begin
                r_next = sh;
                q_next = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign quo = q_reg;

endmodule

@@ src/vzpg_ctrl.sv @@
// ----------------------------------------------------------------------------
// vzpg_ctrl: sequencer for one gesture update
// Steps the datapath through zoom, pan rescale and add, aspect base, size, fit and output.
// ----------------------------------------------------------------------------
module vzpg_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  vzpg_pkg::status_t  sts,
    output vzpg_pkg::cmd_t     cmd
);

    vzpg_pkg::state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       ov_reg, ov_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vzpg_pkg::ST_IDLE;
            axis_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg <= axis_next;
            ov_reg <= ov_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        axis_next = axis_reg;
        ov_next = ov_reg;
        cmd = '0;
        if (ov_reg && m_tready) begin
            ov_next = 1'b0;
        end
        s_tready = (state_reg == vzpg_pkg::ST_IDLE) && !ov_reg;
        m_tvalid = ov_reg;
        case (state_reg)
            vzpg_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.load = 1'b1;
                    state_next = vzpg_pkg::ST_ZOOM;
                end
            end
            vzpg_pkg::ST_ZOOM: begin
                cmd.zoom = 1'b1;
                state_next = sts.vp_zero ? vzpg_pkg::ST_OUT : vzpg_pkg::ST_PANMUL;
            end
            vzpg_pkg::ST_PANMUL: begin
                if (sts.zoom_changed) begin
                    cmd.pan_mul = 1'b1;
                    axis_next = 2'd0;
                    state_next = vzpg_pkg::ST_PANDIV;
                end else begin
                    state_next = vzpg_pkg::ST_PANADD;
                end
            end
            vzpg_pkg::ST_PANDIV: begin
                if (!sts.div_busy) begin
                    if (axis_reg == 2'd2) begin
                        state_next = vzpg_pkg::ST_PANADD;
                    end else begin
                        cmd.div_x_start = 1'b1;
                        axis_next = axis_reg + 2'd1;
                    end
                end
            end
            vzpg_pkg::ST_PANADD: begin
                cmd.pan_add = 1'b1;
                axis_next = 2'd0;
                state_next = sts.has_aspect ? vzpg_pkg::ST_BASEDIV : vzpg_pkg::ST_SIZE;
            end
            vzpg_pkg::ST_BASEDIV: begin
                if (!sts.div_busy) begin
                    if (axis_reg == 2'd1) begin
                        state_next = vzpg_pkg::ST_BASEW;
                    end else begin
                        cmd.base_start = 1'b1;
                        axis_next = 2'd1;
                    end
                end
            end
            vzpg_pkg::ST_BASEW: begin
                cmd.base_w = 1'b1;
                state_next = vzpg_pkg::ST_SIZE;
            end
            vzpg_pkg::ST_SIZE: begin
                cmd.size = 1'b1;
                state_next = vzpg_pkg::ST_FIT;
            end
            vzpg_pkg::ST_FIT: begin
                cmd.fit = 1'b1;
                state_next = vzpg_pkg::ST_OUT;
            end
            vzpg_pkg::ST_OUT: begin
                if (!ov_next) begin
                    cmd.commit = 1'b1;
                    ov_next = 1'b1;
                    state_next = vzpg_pkg::ST_IDLE;
                end
            end
            default: state_next = vzpg_pkg::ST_IDLE;
        endcase
    end

endmodule

@@ src/vzpg_dp.sv @@
// ----------------------------------------------------------------------------
// vzpg_dp: gesture datapath
// Zoom clamp, pan rescale, aspect fit, pan clamp and result register.
// ----------------------------------------------------------------------------
module vzpg_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [13:0]        vp_w,
    input  logic [13:0]        vp_h,
    input  logic [23:0]        aspect,
    input  logic [15:0]        zmax,
    input  logic [89:0]        in_word,
    input  vzpg_pkg::cmd_t     cmd,
    output vzpg_pkg::status_t  sts,
    output logic [151:0]       out_word
);

    logic [15:0] zoom_reg;
    logic signed [21:0] panx_reg, pany_reg;
    logic [15:0] fac_reg, nz_reg;
    logic [17:0] cx_reg, cy_reg;
    logic signed [18:0] dx_reg, dy_reg;
    logic signed [47:0] nx_reg, ny_reg;
    logic signed [40:0] px_reg, py_reg;
    logic [31:0] bw_reg, bh_reg;
    logic [31:0] w_reg, h_reg;
    logic [151:0] out_reg;
    logic         dsel_reg;

    logic [17:0] vw16, vh16;
    logic [15:0] hi;
    logic [31:0] prod;
    logic [19:0] nzr;
    logic [15:0] nz;
    logic        div_start;
    logic [47:0] div_num, quo;
    logic [23:0] div_den;
    logic        div_busy;
    logic signed [47:0] num_sel;
    logic [47:0] mag;
    logic signed [40:0] rq;
    logic [23:0] half_d;

    assign vw16 = {vp_w, 4'd0};
    assign vh16 = {vp_h, 4'd0};
    assign hi = (zmax < 16'(vzpg_pkg::ONE_Q12)) ? 16'(vzpg_pkg::ONE_Q12) : zmax;
    assign prod = zoom_reg * fac_reg;
    assign nzr = 20'((prod + 32'd2048) >> 12);
    assign nz = (nzr < 20'(vzpg_pkg::ONE_Q12)) ? 16'(vzpg_pkg::ONE_Q12) :
                (nzr > {4'd0, hi}) ? hi : nzr[15:0];

    assign sts.vp_zero = (vp_w == '0) || (vp_h == '0);
    assign sts.zoom_changed = (nz_reg != zoom_reg);
    assign sts.has_aspect = (aspect != '0);
    assign sts.div_busy = div_busy;

    // pan division: sign-magnitude, rounded half away from zero
    assign num_sel = dsel_reg ? ny_reg : nx_reg;
    assign half_d = cmd.base_start ? {1'b0, aspect[23:1]} : {9'd0, zoom_reg[15:1]};
    assign mag = num_sel[47] ? 48'(-num_sel) : 48'(num_sel);
    assign div_start = cmd.div_x_start || cmd.base_start;
    assign div_num = cmd.base_start ? 48'({6'd0, vw16, 16'd0}) + 48'(half_d)
                                    : mag + 48'(half_d);
    assign div_den = cmd.base_start ? aspect : {8'd0, zoom_reg};
    assign rq = num_sel[47] ? -41'(quo) : 41'(quo);

    vzpg_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(div_den), .busy(div_busy), .quo(quo)
    );

    logic signed [19:0] ex, ey;
    logic signed [17:0] diff;
    assign ex = $signed({2'b0, cx_reg}) - $signed({2'b0, vw16[17:1]});
    assign ey = $signed({2'b0, cy_reg}) - $signed({2'b0, vh16[17:1]});
    assign diff = $signed({2'b0, zoom_reg}) - $signed({2'b0, nz_reg});

    // fit helpers
    logic signed [33:0] mx, my, lx, ly, cpx, cpy, sx, sy;
    logic [31:0] wq, hq;
    logic [41:0] bwq;
    assign bwq = 42'(vh16) * 42'(aspect) + 42'd32768;
    assign wq = 32'((48'(bw_reg) * 48'(nz_reg) + 48'd2048) >> 12);
    assign hq = 32'((48'(bh_reg) * 48'(nz_reg) + 48'd2048) >> 12);
    assign sx = $signed({2'b0, w_reg}) - $signed(34'(vw16));
    assign sy = $signed({2'b0, h_reg}) - $signed(34'(vh16));
    assign mx = (sx > 0) ? (sx >>> 1) : '0;
    assign my = (sy > 0) ? (sy >>> 1) : '0;
    assign cpx = (34'(px_reg) > mx) ? mx : (34'(px_reg) < -mx) ? -mx : 34'(px_reg);
    assign cpy = (34'(py_reg) > my) ? my : (34'(py_reg) < -my) ? -my : 34'(py_reg);
    assign lx = ((-sx) >>> 1) + cpx;
    assign ly = ((-sy) >>> 1) + cpy;

    function automatic logic [21:0] sat22(input logic signed [40:0] v);
        logic [21:0] r;
        if (v > 41'sd2097151) r = 22'h1FFFFF;
        else if (v < -41'sd2097152) r = 22'h200000;
        else r = v[21:0];
        return r;
    endfunction

    function automatic logic [22:0] sat23(input logic signed [33:0] v);
        logic [22:0] r;
        if (v > 34'sd4194303) r = 23'h3FFFFF;
        else if (v < -34'sd4194304) r = 23'h400000;
        else r = v[22:0];
        return r;
    endfunction

    logic [21:0] wsat, hsat;
    assign wsat = (w_reg > 32'd4194303) ? 22'h3FFFFF : w_reg[21:0];
    assign hsat = (h_reg > 32'd4194303) ? 22'h3FFFFF : h_reg[21:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zoom_reg <= 16'(vzpg_pkg::ONE_Q12);
            panx_reg <= '0;
            pany_reg <= '0;
        end else if (cmd.commit && !sts.vp_zero) begin
            zoom_reg <= nz_reg;
            panx_reg <= $signed(sat22(41'(cpx)));
            pany_reg <= $signed(sat22(41'(cpy)));
        end
        if (cmd.load) begin
            fac_reg <= in_word[15:0];
            cx_reg <= in_word[33:16];
            cy_reg <= in_word[51:34];
            dx_reg <= in_word[70:52];
            dy_reg <= in_word[89:71];
        end
        if (cmd.zoom) begin
            nz_reg <= nz;
            px_reg <= 41'(panx_reg);
            py_reg <= 41'(pany_reg);
            bw_reg <= 32'(vw16);
            bh_reg <= 32'(vh16);
        end
        if (cmd.pan_mul) begin
            nx_reg <= 48'(ex) * 48'(diff) + 48'(panx_reg) * 48'($signed({2'b0, nz_reg}));
            ny_reg <= 48'(ey) * 48'(diff) + 48'(pany_reg) * 48'($signed({2'b0, nz_reg}));
            dsel_reg <= 1'b0;
        end
        if (cmd.div_x_start) begin
            dsel_reg <= 1'b1;
            if (dsel_reg) px_reg <= nx_reg[47] ? -41'(quo) : 41'(quo);
        end
        if (cmd.pan_add) begin
            if (sts.zoom_changed) py_reg <= rq + 41'(dy_reg);
            else py_reg <= py_reg + 41'(dy_reg);
            px_reg <= px_reg + 41'(dx_reg);
        end
        if (cmd.base_w) begin
            if (quo > 48'(vh16)) begin
                bh_reg <= 32'(vh16);
                bw_reg <= 32'(bwq >> 16);
            end else begin
                bh_reg <= quo[31:0];
            end
        end
        if (cmd.size) begin
            w_reg <= wq;
            h_reg <= hq;
        end
        if (cmd.commit) begin
            if (sts.vp_zero) out_reg <= {92'd0, pany_reg, panx_reg, zoom_reg};
            else out_reg <= {2'd0, hsat, wsat, sat23(ly), sat23(lx),
                             sat22(41'(cpy)), sat22(41'(cpx)), nz_reg};
        end
    end

    assign out_word = out_reg;

endmodule

@@ src/view_zoom_pan_gesture_top.sv @@
// The pan rescale (two divides) runs only when the zoom changes, and the aspect
// divide only when an aspect is set.
// One word at a time: the next word is accepted the cycle after the result is taken;
// the shared bit-serial divider sets the worst case.
// Reset (aresetn, synchronous, active low): zoom 1.0, pan 0, registers at defaults.
// ----------------------------------------------------------------------------
// view_zoom_pan_gesture_top: pinch zoom / pan with letterbox fit
// Config registers, controller and datapath.
// ----------------------------------------------------------------------------
module view_zoom_pan_gesture_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [23:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // zoom_factor, centroid_x, centroid_y, pan_delta_x, pan_delta_y
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_zoom, new_pan_x, new_pan_y, rect_left, rect_top, rect_width, rect_height
    output logic [151:0] m_tdata
);

    logic [13:0] vpw_reg, vph_reg;
    logic [23:0] asp_reg;
    logic [15:0] zmax_reg;
    vzpg_pkg::cmd_t    cmd;
    vzpg_pkg::status_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vpw_reg <= '0;
            vph_reg <= '0;
            asp_reg <= '0;
            zmax_reg <= 16'd32768;
        end else if (cfg_we) begin
            case (cfg_addr)
                vzpg_pkg::REG_VP_WIDTH:  vpw_reg <= cfg_wdata[13:0];
                vzpg_pkg::REG_VP_HEIGHT: vph_reg <= cfg_wdata[13:0];
                vzpg_pkg::REG_ASPECT:    asp_reg <= cfg_wdata;
                vzpg_pkg::REG_MAX_ZOOM:  zmax_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    vzpg_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .sts(sts), .cmd(cmd)
    );

    vzpg_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .vp_w(vpw_reg), .vp_h(vph_reg),
        .aspect(asp_reg), .zmax(zmax_reg), .in_word(s_tdata[89:0]),
        .cmd(cmd), .sts(sts), .out_word(m_tdata)
    );

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for view_zoom_pan_gesture_top
// Sends gesture words, predicts each transform and fitted rectangle, and
// compares every result word field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 250;

    typedef struct packed {
        logic signed [18:0] pan_dy;
        logic signed [18:0] pan_dx;
        logic [17:0]        cy;
        logic [17:0]        cx;
        logic [15:0]        factor;
    } gesture_t;

    typedef struct packed {
        logic [21:0]        rect_h;
        logic [21:0]        rect_w;
        logic signed [22:0] rect_top;
        logic signed [22:0] rect_left;
        logic signed [21:0] pan_y;
        logic signed [21:0] pan_x;
        logic [15:0]        zoom;
    } view_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [23:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;

    view_zoom_pan_gesture_top DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor copy of registers and transform
    longint vp_w, vp_h, aspect, zoom_max;
    longint cur_zoom, cur_pan_x, cur_pan_y;

    view_t expected_views[$];
    int errors;
    int idle_cycles;
    int hold_cycles;
    int stall_left;
    bit no_idle;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint round_div(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint floor_half(longint v);
        return v >= 0 ? v / 2 : -((-v + 1) / 2);
    endfunction

    function automatic longint fit_edge(longint size, longint vp, inout longint pan);
        longint m;
        m = size > vp ? floor_half(size - vp) : 0;
        pan = clip(pan, -m, m);
        return floor_half(vp - size) + pan;
    endfunction

    function automatic view_t predict_view(gesture_t g);
        view_t  r;
        longint vw, vh, old_z, hi_z, nz, px, py, bw, bh, w, h, lft, tp;
        vw = vp_w * 16;
        vh = vp_h * 16;
        r = '0;
        if (vw == 0 || vh == 0) begin
            r.zoom  = cur_zoom[15:0];
            r.pan_x = cur_pan_x[21:0];
            r.pan_y = cur_pan_y[21:0];
            return r;
        end
        old_z = cur_zoom != 0 ? cur_zoom : vzpg_pkg::ONE_Q12;
        hi_z  = zoom_max < vzpg_pkg::ONE_Q12 ? vzpg_pkg::ONE_Q12 : zoom_max;
        nz = (old_z * longint'(g.factor) + 2048) >>> 12;
        nz = clip(nz, vzpg_pkg::ONE_Q12, hi_z);
        px = cur_pan_x;
        py = cur_pan_y;
        if (nz != old_z) begin
            px = round_div((longint'(g.cx) - vw / 2) * (old_z - nz) + px * nz, old_z);
            py = round_div((longint'(g.cy) - vh / 2) * (old_z - nz) + py * nz, old_z);
        end
        px += longint'(g.pan_dx);
        py += longint'(g.pan_dy);
        bw = vw;
        bh = vh;
        if (aspect != 0) begin
            bh = (vw * 65536 + aspect / 2) / aspect;
            if (bh > vh) begin
                bh = vh;
                bw = (vh * aspect + 32768) / 65536;
            end
        end
        w = (bw * nz + 2048) / 4096;
        h = (bh * nz + 2048) / 4096;
        lft = fit_edge(w, vw, px);
        tp  = fit_edge(h, vh, py);
        cur_zoom  = nz;
        cur_pan_x = clip(px, -2097152, 2097151);
        cur_pan_y = clip(py, -2097152, 2097151);
        lft = clip(lft, -4194304, 4194303);
        tp  = clip(tp, -4194304, 4194303);
        w   = clip(w, 0, 4194303);
        h   = clip(h, 0, 4194303);
        r.zoom      = nz[15:0];
        r.pan_x     = cur_pan_x[21:0];
        r.pan_y     = cur_pan_y[21:0];
        r.rect_left = lft[22:0];
        r.rect_top  = tp[22:0];
        r.rect_w    = w[21:0];
        r.rect_h    = h[21:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [22:0] got, logic [22:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    function automatic int pick_gap();
        if (no_idle || $urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 150);
        return $urandom_range(1, 4);
    endfunction

    task automatic send_gesture(gesture_t g);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, g};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_views.push_back(predict_view(g));
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (expected_views.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, longint val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[23:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            vzpg_pkg::REG_VP_WIDTH:  vp_w = val & 14'h3FFF;
            vzpg_pkg::REG_VP_HEIGHT: vp_h = val & 14'h3FFF;
            vzpg_pkg::REG_ASPECT:    aspect = val & 24'hFFFFFF;
            vzpg_pkg::REG_MAX_ZOOM:  zoom_max = val & 16'hFFFF;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic configure(longint w, longint h, longint a, longint mz);
        wait_results();
        write_reg(vzpg_pkg::REG_VP_WIDTH, w);
        write_reg(vzpg_pkg::REG_VP_HEIGHT, h);
        write_reg(vzpg_pkg::REG_ASPECT, a);
        write_reg(vzpg_pkg::REG_MAX_ZOOM, mz);
    endtask

    function automatic gesture_t make_gesture(longint f, longint x, longint y,
                                              longint dx, longint dy);
        gesture_t g;
        g.factor = f[15:0];
        g.cx     = x[17:0];
        g.cy     = y[17:0];
        g.pan_dx = dx[18:0];
        g.pan_dy = dy[18:0];
        return g;
    endfunction

    function automatic gesture_t rand_gesture();
        gesture_t g;
        g = gesture_t'(90'({$urandom, $urandom, $urandom}));
        case ($urandom_range(0, 9))
            0: ;
            1, 2: g.factor = 16'd4096;
            default: g.factor = 16'($urandom_range(2800, 6000));
        endcase
        if ($urandom_range(0, 4) != 0) begin
            g.cx = 18'($urandom_range(0, 32'(vp_w * 16)));
            g.cy = 18'($urandom_range(0, 32'(vp_h * 16)));
        end
        if ($urandom_range(0, 4) != 0) begin
            g.pan_dx = $signed(19'($urandom_range(0, 2047))) - 19'sd1024;
            g.pan_dy = $signed(19'($urandom_range(0, 2047))) - 19'sd1024;
        end
        return g;
    endfunction

    // result side: stalls, pressure hold-off and checking
    always @(posedge aclk) begin
        view_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (m_tvalid && m_tready) begin
                got = view_t'(m_tdata[149:0]);
                if (expected_views.size() == 0) begin
                    report_mismatch("unexpected word", 23'(got.zoom), '0);
                end else begin
                    want = expected_views.pop_front();
                    if (got.zoom != want.zoom)
                        report_mismatch("new_zoom", 23'(got.zoom), 23'(want.zoom));
                    if (got.pan_x != want.pan_x)
                        report_mismatch("new_pan_x", 23'(got.pan_x), 23'(want.pan_x));
                    if (got.pan_y != want.pan_y)
                        report_mismatch("new_pan_y", 23'(got.pan_y), 23'(want.pan_y));
                    if (got.rect_left != want.rect_left)
                        report_mismatch("rect_left", got.rect_left, want.rect_left);
                    if (got.rect_top != want.rect_top)
                        report_mismatch("rect_top", got.rect_top, want.rect_top);
                    if (got.rect_w != want.rect_w)
                        report_mismatch("rect_width", 23'(got.rect_w), 23'(want.rect_w));
                    if (got.rect_h != want.rect_h)
                        report_mismatch("rect_height", 23'(got.rect_h), 23'(want.rect_h));
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                            : $urandom_range(1, 4);
            end
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic test_zero_viewport();
        send_gesture(make_gesture(8192, 100, 100, 50, -50));
        send_gesture(make_gesture(65535, 262143, 0, 262143, -262144));
        configure(100, 0, 0, 32768);
        send_gesture(make_gesture(8192, 800, 800, 16, 16));
        configure(0, 50, 0, 32768);
        send_gesture(make_gesture(2048, 0, 0, -16, 16));
    endtask

    task automatic test_directed();
        configure(1920, 1080, 116508, 32768);
        send_gesture(make_gesture(4096, 15360, 8640, 0, 0));
        send_gesture(make_gesture(8192, 0, 0, 0, 0));
        send_gesture(make_gesture(8192, 30720, 17280, 100, -100));
        send_gesture(make_gesture(65535, 262143, 262143, 0, 0));
        send_gesture(make_gesture(4096, 0, 0, 262143, 262143));
        send_gesture(make_gesture(4096, 0, 0, -262144, -262144));
        send_gesture(make_gesture(0, 262143, 0, 0, 0));
        send_gesture(make_gesture(2048, 1000, 1000, 5, 5));
        configure(1920, 1080, 0, 0);
        send_gesture(make_gesture(65535, 200, 300, 40, 40));
        send_gesture(make_gesture(8192, 200, 300, 40, 40));
        configure(16383, 16383, 16777215, 65535);
        send_gesture(make_gesture(65535, 131064, 131064, 0, 0));
        send_gesture(make_gesture(65535, 0, 262143, 262143, -262144));
        send_gesture(make_gesture(4096, 0, 0, -262144, 262143));
        configure(16383, 1, 1, 65535);
        send_gesture(make_gesture(65535, 0, 0, 262143, 262143));
        send_gesture(make_gesture(1, 262143, 262143, -262144, -262144));
        configure(1, 16383, 65536, 4096);
        send_gesture(make_gesture(65535, 8, 8, 1, -1));
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: configure(1920, 1080, 116508, 32768);
                1: configure(1080, 1920, 116508, 16384);
                2: configure(800, 600, 0, 65535);
                3: configure(640, 480, 65536, 4095);
                default: configure($urandom_range(1, 16383), $urandom_range(1, 16383),
                                   $urandom & 24'hFFFFFF, $urandom_range(0, 65535));
            endcase
            no_idle = (phase == 2);
            repeat (110) send_gesture(rand_gesture());
            no_idle = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        configure(1280, 720, 116508, 32768);
        hold_cycles = 600;
        no_idle = 1'b1;
        repeat (12) send_gesture(rand_gesture());
        no_idle = 1'b0;
        wait_results();
        repeat (40) send_gesture(rand_gesture());
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        errors = 0;
        idle_cycles = 0;
        hold_cycles = 0;
        stall_left = 0;
        no_idle = 1'b0;
        vp_w = 0;
        vp_h = 0;
        aspect = 0;
        zoom_max = 32768;
        cur_zoom = vzpg_pkg::ONE_Q12;
        cur_pan_x = 0;
        cur_pan_y = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_zero_viewport();
        test_directed();
        test_random_settings();
        test_backpressure();
        wait_results();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

@@ view_zoom_pan_gesture_top.f @@
src/vzpg_pkg.sv
src/vzpg_div.sv
src/vzpg_ctrl.sv
src/vzpg_dp.sv
src/view_zoom_pan_gesture_top.sv
sim/testbench.sv
